// ===== hw/rtl/pfp_pkg.sv =====
package pfp_pkg;

    localparam logic [7:0] START_BYTE     = 8'h42;
    localparam logic [4:0] POS_LAST       = 5'd31;
    localparam logic [4:0] SUM_BYTES      = 5'd30;
    localparam logic [4:0] POS_LAST_STORE = 5'd27;
    localparam logic [4:0] POS_FIRST_WORD = 5'd2;
    localparam logic [3:0] WORD_IDX_LAST  = 4'd12;
    localparam int         RAM_DEPTH      = 32;
    localparam int         RAM_AW         = 5;
    localparam int         WORD_W         = 16;
    localparam logic [1:0] BANKS          = 2'd2;

    typedef struct packed {
        logic ok;
        logic bank;
    } t_cmd;

endpackage

// ===== hw/rtl/pfp_ram.sv =====
module pfp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/pfp_front.sv =====
module pfp_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [7:0]                i_rx_byte,
    output logic                      o_ready,
    input  logic                      i_release,
    output logic                      o_push,
    output pfp_pkg::t_cmd             o_cmd,
    output logic                      o_we,
    output logic [pfp_pkg::RAM_AW-1:0] o_waddr,
    output logic [pfp_pkg::WORD_W-1:0] o_wdata
);

    logic        r_in_frame, n_in_frame;
    logic [4:0]  r_pos, n_pos;
    logic [15:0] r_sum, n_sum;
    logic [7:0]  r_high, n_high;
    logic        r_bank, n_bank;
    logic [1:0]  r_busy, n_busy;
    logic        accept;
    logic [15:0] word;
    logic [3:0]  widx;

    assign o_ready = !(r_in_frame && (r_busy == pfp_pkg::BANKS));
    assign accept  = i_valid && o_ready;
    assign word    = {r_high, i_rx_byte};
    assign widx    = r_pos[4:1] - 4'd1;

    assign o_wdata = word;
    assign o_waddr = {r_bank, widx};
    assign o_cmd.ok   = (word == r_sum);
    assign o_cmd.bank = r_bank;

    always_comb begin
        n_in_frame = r_in_frame;
        n_pos      = r_pos;
        n_sum      = r_sum;
        n_high     = r_high;
        n_bank     = r_bank;
        o_we       = 1'b0;
        o_push     = 1'b0;
        if (accept) begin
            if (!r_in_frame) begin
                if (i_rx_byte == pfp_pkg::START_BYTE) begin
                    n_in_frame = 1'b1;
                    n_pos      = 5'd1;
                    n_sum      = {8'd0, pfp_pkg::START_BYTE};
                end
            end else begin
                if (r_pos < pfp_pkg::SUM_BYTES) begin
                    n_sum = r_sum + {8'd0, i_rx_byte};
                end
                n_pos = r_pos + 5'd1;
                if (r_pos >= pfp_pkg::POS_FIRST_WORD) begin
                    if (!r_pos[0]) begin
                        n_high = i_rx_byte;
                    end else begin
                        o_we = (r_pos <= pfp_pkg::POS_LAST_STORE);
                        if (r_pos == pfp_pkg::POS_LAST) begin
                            o_push     = 1'b1;
                            n_in_frame = 1'b0;
                            n_pos      = 5'd0;
                            n_bank     = !r_bank;
                        end
                    end
                end
            end
        end
        n_busy = r_busy + {1'b0, o_push} - {1'b0, i_release};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_pos      <= 5'd0;
            r_sum      <= 16'd0;
            r_high     <= 8'd0;
            r_bank     <= 1'b0;
            r_busy     <= 2'd0;
        end else begin
            r_in_frame <= n_in_frame;
            r_pos      <= n_pos;
            r_sum      <= n_sum;
            r_high     <= n_high;
            r_bank     <= n_bank;
            r_busy     <= n_busy;
        end
    end

    a_busy_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy <= pfp_pkg::BANKS)
        else $error("More frames outstanding than there are banks.");

    a_push_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> !r_in_frame && (r_pos == 5'd0))
        else $error("Frame did not end after its transaction was queued.");

endmodule

// ===== hw/rtl/pfp_cmdq.sv =====
module pfp_cmdq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pfp_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_valid,
    output pfp_pkg::t_cmd o_cmd
);

    pfp_pkg::t_cmd r_mem [2];
    logic          r_wptr;
    logic          r_rptr;
    logic [1:0]    r_count;

    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && (r_count == 2'd2) && !i_pop))
        else $error("Command queue overflow.");

endmodule

// ===== hw/rtl/pfp_back.sv =====
module pfp_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    input  pfp_pkg::t_cmd              i_cmd,
    output logic                       o_pop,
    output logic [pfp_pkg::RAM_AW-1:0] o_raddr,
    input  logic [pfp_pkg::WORD_W-1:0] i_rdata,
    output logic                       o_release,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [3:0]                 o_word_index,
    output logic [15:0]                o_word_value,
    output logic                       o_checksum_ok,
    output logic                       o_last
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_LD   = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]  r_state, n_state;
    logic [3:0]  r_k, n_k;
    logic        r_bank, n_bank;
    logic [3:0]  r_idx, n_idx;
    logic [15:0] r_value, n_value;
    logic        r_ok, n_ok;
    logic        r_last, n_last;

    assign o_raddr       = {r_bank, r_k};
    assign o_valid       = (r_state == S_OUT);
    assign o_word_index  = r_idx;
    assign o_word_value  = r_value;
    assign o_checksum_ok = r_ok;
    assign o_last        = r_last;

    always_comb begin
        n_state   = r_state;
        n_k       = r_k;
        n_bank    = r_bank;
        n_idx     = r_idx;
        n_value   = r_value;
        n_ok      = r_ok;
        n_last    = r_last;
        o_pop     = 1'b0;
        o_release = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_pop  = 1'b1;
                    n_bank = i_cmd.bank;
                    n_k    = 4'd0;
                    if (i_cmd.ok) begin
                        n_state = S_RD;
                    end else begin
                        n_idx   = 4'd0;
                        n_value = 16'd0;
                        n_ok    = 1'b0;
                        n_last  = 1'b1;
                        n_state = S_OUT;
                    end
                end
            end
            S_RD: begin
                n_state = S_LD;
            end
            S_LD: begin
                n_idx   = r_k;
                n_value = i_rdata;
                n_ok    = 1'b1;
                n_last  = (r_k == pfp_pkg::WORD_IDX_LAST);
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_ready) begin
                    if (r_last) begin
                        o_release = 1'b1;
                        n_state   = S_IDLE;
                    end else begin
                        n_k     = r_k + 4'd1;
                        n_state = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_k     <= n_k;
        r_bank  <= n_bank;
        r_idx   <= n_idx;
        r_value <= n_value;
        r_ok    <= n_ok;
        r_last  <= n_last;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_last_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_checksum_ok && o_last) |-> (o_word_index == pfp_pkg::WORD_IDX_LAST))
        else $error("Good frame ended on the wrong word.");

    a_fail_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_checksum_ok) |-> (o_last && (o_word_index == 4'd0)))
        else $error("Checksum failure transaction is malformed.");

endmodule

// ===== hw/rtl/particle_frame_parser.sv =====
// Particle sensor frame parser.
// The input channel (i_valid, o_ready, i_rx_byte) takes one received serial byte
// per transaction. While hunting, bytes other than 0x42 are dropped; a 0x42 opens a
// 32-byte frame whose words are written into one of two banks of a word RAM.
// The output channel (o_valid, i_ready) delivers, per frame, either the thirteen
// stored words in order with o_checksum_ok set, or one failure transaction with
// o_checksum_ok clear; o_last marks the final transaction of each frame.
// The front end accepts a valid byte whenever o_ready is high. Once the final byte
// of a frame is accepted, its command enters the queue; the idle back end pops it
// and, for a good frame, sends each word through a RAM read, a load into the
// output register and output; a checksum failure goes straight to output.
// A two-entry command queue lets the front end keep parsing the next frame while the
// back end drains; o_ready drops only inside a frame when both banks still hold
// undelivered frames. When the receiver stalls, the current result holds in the
// output register and the back end waits.
// Reset returns the parser to hunting and empties the queue and the back end.
module particle_frame_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_word_index,
    output logic [15:0] o_word_value,
    output logic        o_checksum_ok,
    output logic        o_last
);

    logic                       push;
    logic                       pop;
    logic                       release_bank;
    logic                       q_valid;
    pfp_pkg::t_cmd              cmd_in;
    pfp_pkg::t_cmd              cmd_out;
    logic                       we;
    logic [pfp_pkg::RAM_AW-1:0] waddr;
    logic [pfp_pkg::RAM_AW-1:0] raddr;
    logic [pfp_pkg::WORD_W-1:0] wdata;
    logic [pfp_pkg::WORD_W-1:0] rdata;

    pfp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_rx_byte (i_rx_byte),
        .o_ready   (o_ready),
        .i_release (release_bank),
        .o_push    (push),
        .o_cmd     (cmd_in),
        .o_we      (we),
        .o_waddr   (waddr),
        .o_wdata   (wdata)
    );

    pfp_ram #(
        .WIDTH (pfp_pkg::WORD_W),
        .DEPTH (pfp_pkg::RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    pfp_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (cmd_out)
    );

    pfp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_cmd         (cmd_out),
        .o_pop         (pop),
        .o_raddr       (raddr),
        .i_rdata       (rdata),
        .o_release     (release_bank),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_word_index  (o_word_index),
        .o_word_value  (o_word_value),
        .o_checksum_ok (o_checksum_ok),
        .o_last        (o_last)
    );

endmodule

// ===== bench/particle_frame_parser_checker.sv =====
`timescale 1ns / 100ps

module particle_frame_parser_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [3:0]  i_word_index,
    input  logic [15:0] i_word_value,
    input  logic        i_checksum_ok,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [3:0]  word_index;
        logic [15:0] word_value;
        logic        checksum_ok;
        logic        last;
    } t_frame_result;

    t_frame_result expected_results[$];

    logic        in_frame  = 1'b0;
    logic [4:0]  byte_pos  = 5'd0;
    logic [15:0] frame_sum = 16'd0;
    logic [7:0]  high_byte = 8'd0;
    logic [15:0] word_store [0:pfp_pkg::WORD_IDX_LAST];
    int          fail_count = 0;
    int          pending    = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;

    task automatic parse_byte(input logic [7:0] rx);
        logic [15:0]   word;
        t_frame_result res;
        int            k;
        if (!in_frame) begin
            if (rx == pfp_pkg::START_BYTE) begin
                in_frame  = 1'b1;
                byte_pos  = 5'd1;
                frame_sum = {8'h00, pfp_pkg::START_BYTE};
            end
        end else begin
            if (byte_pos < pfp_pkg::SUM_BYTES) begin
                frame_sum = frame_sum + {8'h00, rx};
            end
            if (byte_pos >= pfp_pkg::POS_FIRST_WORD && !byte_pos[0]) begin
                high_byte = rx;
            end else if (byte_pos >= pfp_pkg::POS_FIRST_WORD) begin
                word = {high_byte, rx};
                if (byte_pos <= pfp_pkg::POS_LAST_STORE) begin
                    word_store[(byte_pos - pfp_pkg::POS_FIRST_WORD) >> 1] = word;
                end
            end
            if (byte_pos == pfp_pkg::POS_LAST) begin
                in_frame = 1'b0;
                byte_pos = 5'd0;
                if (word == frame_sum) begin
                    for (k = 0; k <= pfp_pkg::WORD_IDX_LAST; k++) begin
                        res.word_index  = 4'(k);
                        res.word_value  = word_store[k];
                        res.checksum_ok = 1'b1;
                        res.last        = (4'(k) == pfp_pkg::WORD_IDX_LAST);
                        expected_results.push_back(res);
                    end
                end else begin
                    res.word_index  = 4'd0;
                    res.word_value  = 16'd0;
                    res.checksum_ok = 1'b0;
                    res.last        = 1'b1;
                    expected_results.push_back(res);
                end
            end else begin
                byte_pos = byte_pos + 5'd1;
            end
        end
    endtask

    task automatic check_result();
        t_frame_result want;
        if (expected_results.size() == 0) begin
            $error("unexpected transaction: word_index %0d word_value 0x%04h",
                   i_word_index, i_word_value);
            fail_count++;
        end else begin
            want = expected_results.pop_front();
            if (i_word_index !== want.word_index) begin
                $error("word_index: expected %0d, actual %0d", want.word_index, i_word_index);
                fail_count++;
            end
            if (i_word_value !== want.word_value) begin
                $error("word_value: expected 0x%04h, actual 0x%04h",
                       want.word_value, i_word_value);
                fail_count++;
            end
            if (i_checksum_ok !== want.checksum_ok) begin
                $error("checksum_ok: expected %0b, actual %0b", want.checksum_ok, i_checksum_ok);
                fail_count++;
            end
            if (i_last !== want.last) begin
                $error("last: expected %0b, actual %0b", want.last, i_last);
                fail_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_frame  = 1'b0;
            byte_pos  = 5'd0;
            frame_sum = 16'd0;
            high_byte = 8'd0;
            expected_results.delete();
            pending <= 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                parse_byte(i_rx_byte);
            end
            if (i_out_valid && i_out_ready) begin
                check_result();
            end
            pending <= expected_results.size();
        end
    end

endmodule

// ===== bench/particle_frame_parser_tb.sv =====
`timescale 1ns / 100ps

module particle_frame_parser_tb;

    localparam int         RANDOM_FRAME_BYTES = 80;
    localparam int         CYCLE_LIMIT        = 200000;
    localparam int         DRAIN_CYCLES       = 60;
    localparam logic [7:0] HEADER_SECOND      = 8'h4D;

    typedef enum logic [1:0] {FILL_ZERO, FILL_MAX, FILL_RANDOM} t_fill;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        i_valid   = 1'b0;
    logic [7:0]  i_rx_byte = 8'd0;
    logic        i_ready   = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [3:0]  o_word_index;
    logic [15:0] o_word_value;
    logic        o_checksum_ok;
    logic        o_last;

    logic        quiet  = 1'b0;
    int          cycles = 0;
    int          fail_count;
    int          pending;
    logic [7:0]  frame_bytes [0:31];

    particle_frame_parser uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_rx_byte     (i_rx_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_word_index  (o_word_index),
        .o_word_value  (o_word_value),
        .o_checksum_ok (o_checksum_ok),
        .o_last        (o_last)
    );

    particle_frame_parser_checker frame_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_rx_byte     (i_rx_byte),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_word_index  (o_word_index),
        .i_word_value  (o_word_value),
        .i_checksum_ok (o_checksum_ok),
        .i_last        (o_last),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles  <= cycles + 1;
        i_ready <= quiet || ($urandom_range(0, 99) >= 8);
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] rx);
        while (!quiet && $urandom_range(0, 99) < 8) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= rx;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
    endtask

    function automatic void build_frame(input t_fill fill, input logic [7:0] second,
                                        input logic good);
        logic [15:0] sum;
        logic [15:0] sum_field;
        int          i;
        frame_bytes[0] = pfp_pkg::START_BYTE;
        frame_bytes[1] = second;
        for (i = 2; i < 30; i++) begin
            case (fill)
                FILL_ZERO: frame_bytes[i] = 8'h00;
                FILL_MAX:  frame_bytes[i] = 8'hFF;
                default:   frame_bytes[i] = 8'($urandom_range(0, 255));
            endcase
        end
        sum = 16'd0;
        for (i = 0; i < 30; i++) begin
            sum = sum + {8'h00, frame_bytes[i]};
        end
        sum_field      = good ? sum : sum ^ 16'($urandom_range(1, 16'hFFFF));
        frame_bytes[30] = sum_field[15:8];
        frame_bytes[31] = sum_field[7:0];
    endfunction

    task automatic send_frame();
        int i;
        for (i = 0; i < 32; i++) begin
            send_byte(frame_bytes[i]);
        end
    endtask

    initial begin
        int          sent;
        int          round;
        int          pick;
        int          n;
        logic [7:0]  noise;
        logic [7:0]  second;
        t_fill       fill;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Bytes seen while hunting are dropped.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h41);
        send_byte(8'h43);
        send_byte(8'hBD);

        build_frame(FILL_ZERO, HEADER_SECOND, 1'b1);
        send_frame();
        build_frame(FILL_MAX, HEADER_SECOND, 1'b1);
        send_frame();

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end

        // The second header byte is never checked.
        build_frame(FILL_MAX, pfp_pkg::START_BYTE, 1'b0);
        send_frame();
        build_frame(FILL_RANDOM, 8'h00, 1'b1);
        send_frame();

        sent  = 0;
        round = 0;
        while (sent < RANDOM_FRAME_BYTES) begin
            quiet <= (round >= 1 && round <= 3);
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                repeat ($urandom_range(1, 6)) begin
                    noise = 8'($urandom_range(0, 255));
                    if (noise == pfp_pkg::START_BYTE) begin
                        noise = ~noise;
                    end
                    send_byte(noise);
                end
            end else if (pick < 25) begin
                n = $urandom_range(1, 30);
                send_byte(pfp_pkg::START_BYTE);
                repeat (n) begin
                    send_byte(8'($urandom_range(0, 255)));
                end
                sent += n + 1;
            end else begin
                fill   = (pick < 30) ? FILL_MAX : (pick < 35) ? FILL_ZERO : FILL_RANDOM;
                second = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                     : HEADER_SECOND;
                build_frame(fill, second, $urandom_range(0, 3) != 0);
                send_frame();
                sent += 32;
            end
            round++;
        end

        i_valid <= 1'b0;
        quiet   <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
